@@ hw/rtl/snd_pkg.sv @@
package snd_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W         = 8;
   localparam int OUT_W         = 24;

   // lattice coordinates and offsets inside one simplex
   localparam int POS_W   = FRAC_BITS + 4;
   localparam int CI_W    = 35 - FRAC_BITS;
   localparam int PART_W  = 2 * POS_W + 6 - FRAC_BITS;
   localparam int SUM_W   = PART_W + 2;
   localparam int SCALE_W = SUM_W + 6;

   // pipeline registers inside one corner unit
   localparam int CORNER_LAT = 7;

   localparam logic signed [32:0] F2_Q32 = 33'sd1572067139;
   localparam logic signed [30:0] G2_Q32 = 31'sd907633386;
   localparam int G2F_INT = (907633386 + (1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

   localparam logic signed [POS_W-1:0] ONE_POS  = POS_W'(1 << FRAC_BITS);
   localparam logic signed [POS_W-1:0] G2F_POS  = POS_W'(G2F_INT);
   localparam logic signed [POS_W-1:0] G2F2_POS = POS_W'(2 * G2F_INT - (1 << FRAC_BITS));
   localparam logic signed [2*POS_W+1:0] HALF_SQ =
      (2 * POS_W + 2)'(64'sd1 << (2 * FRAC_BITS - 1));

   localparam logic signed [SCALE_W-1:0] OUT_MAX_S = SCALE_W'(8388607);
   localparam logic signed [SCALE_W-1:0] OUT_MIN_S = SCALE_W'(-8388608);

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } opcode_type;

   typedef struct packed {
      logic signed [PART_W-1:0] noise;
      logic signed [PART_W-1:0] grad_x;
      logic signed [PART_W-1:0] grad_y;
   } corner_out_type;

   localparam logic [7:0] DEFAULT_PERM [TABLE_ENTRIES] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
      8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
      8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
      8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
      8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
      8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
      8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
      8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
      8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
      8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
      8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
      8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
      8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
      8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
      8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
      8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
      8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
      8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
      8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
      8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
      8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
      8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
   };

   function automatic logic signed [1:0] grad_tab_x(input logic [2:0] h);
      logic signed [1:0] g;
      case (h)
         3'd0:    g = -2'sd1;
         3'd1:    g = 2'sd1;
         3'd2:    g = -2'sd1;
         3'd3:    g = 2'sd1;
         3'd4:    g = -2'sd1;
         3'd5:    g = 2'sd0;
         3'd6:    g = 2'sd0;
         default: g = 2'sd1;
      endcase
      return g;
   endfunction

   function automatic logic signed [1:0] grad_tab_y(input logic [2:0] h);
      logic signed [1:0] g;
      case (h)
         3'd0:    g = -2'sd1;
         3'd1:    g = 2'sd0;
         3'd2:    g = 2'sd0;
         3'd3:    g = 2'sd1;
         3'd4:    g = 2'sd1;
         3'd5:    g = -2'sd1;
         3'd6:    g = 2'sd1;
         default: g = -2'sd1;
      endcase
      return g;
   endfunction

   // scale by 40 and clamp to the output range
   function automatic logic [OUT_W-1:0] scale_sat(input logic signed [SUM_W-1:0] v);
      logic signed [SCALE_W-1:0] w;
      logic signed [SCALE_W-1:0] r;
      w = (SCALE_W'(v) <<< 5) + (SCALE_W'(v) <<< 3);
      if (w > OUT_MAX_S) begin
         r = OUT_MAX_S;
      end else if (w < OUT_MIN_S) begin
         r = OUT_MIN_S;
      end else begin
         r = w;
      end
      return r[OUT_W-1:0];
   endfunction

endpackage

@@ hw/rtl/snd_corner.sv @@
module snd_corner (
   input  logic                                  clock,
   input  logic                                  adv,
   input  logic signed [snd_pkg::POS_W-1:0]      pos_x,
   input  logic signed [snd_pkg::POS_W-1:0]      pos_y,
   input  logic [2:0]                            hash,
   output snd_pkg::corner_out_type               part
);

   localparam int F   = snd_pkg::FRAC_BITS;
   localparam int PW  = snd_pkg::POS_W;
   localparam int VW  = PW + 1;
   localparam int SQW = 2 * PW;
   localparam int TW  = 2 * PW + 2;
   localparam int MW  = F + PW + 2;
   localparam int NW  = PW + 2;
   localparam int XW  = 2 * PW + 2;
   localparam int GW  = snd_pkg::PART_W;

   // stage A: squares and dot product
   logic signed [SQW-1:0] a_sqx_ff, a_sqy_ff;
   logic signed [VW-1:0]  a_v_ff, a_v_in;
   logic signed [1:0]     a_ax_ff, a_ay_ff, ax_w, ay_w;
   logic signed [PW-1:0]  a_px_ff, a_py_ff;
   logic signed [VW-1:0]  tx, ty;

   always_comb begin
      ax_w = snd_pkg::grad_tab_x(hash);
      ay_w = snd_pkg::grad_tab_y(hash);
      case (ax_w)
         2'sb01:  tx = VW'(pos_x);
         2'sb11:  tx = -VW'(pos_x);
         default: tx = '0;
      endcase
      case (ay_w)
         2'sb01:  ty = VW'(pos_y);
         2'sb11:  ty = -VW'(pos_y);
         default: ty = '0;
      endcase
      a_v_in = tx + ty;
   end

   // stage B: falloff t
   logic [F-1:0]          b_t_ff, b_t_in;
   logic signed [TW-1:0]  tt;
   logic signed [VW-1:0]  b_v_ff;
   logic signed [1:0]     b_ax_ff, b_ay_ff;
   logic signed [PW-1:0]  b_px_ff, b_py_ff;

   always_comb begin
      tt = snd_pkg::HALF_SQ - (TW'(a_sqx_ff) + TW'(a_sqy_ff));
      if (tt < 0) begin
         b_t_in = '0;
      end else begin
         b_t_in = tt[2*F-1:F];
      end
   end

   // stage C: t^2 product
   logic [2*F-1:0]        c_tt_ff;
   logic [F-1:0]          c_t_ff;
   logic signed [VW-1:0]  c_v_ff;
   logic signed [1:0]     c_ax_ff, c_ay_ff;
   logic signed [PW-1:0]  c_px_ff, c_py_ff;

   // stage D: t^3 and t^4 products
   logic [F-1:0]          t2;
   logic [2*F-1:0]        d_t3p_ff, d_t4p_ff;
   logic signed [VW-1:0]  d_v_ff;
   logic signed [1:0]     d_ax_ff, d_ay_ff;
   logic signed [PW-1:0]  d_px_ff, d_py_ff;

   assign t2 = c_tt_ff[2*F-1:F];

   // stage E: weighted dot products
   logic [F-1:0]          t3, t4;
   logic signed [MW-1:0]  e_t4v_ff, e_t3v_ff;
   logic [F-1:0]          e_t4_ff;
   logic signed [1:0]     e_ax_ff, e_ay_ff;
   logic signed [PW-1:0]  e_px_ff, e_py_ff;

   assign t3 = d_t3p_ff[2*F-1:F];
   assign t4 = d_t4p_ff[2*F-1:F];

   // stage F: noise part and position times t^3 v
   logic signed [NW-1:0]  f_n_ff, w;
   logic signed [XW-1:0]  f_pxw_ff, f_pyw_ff;
   logic [F-1:0]          f_t4_ff;
   logic signed [1:0]     f_ax_ff, f_ay_ff;

   assign w = e_t3v_ff[MW-1:F];

   // stage G: gradient parts
   snd_pkg::corner_out_type part_ff, part_in;
   logic signed [XW-F-1:0] gxs, gys;
   logic signed [GW-1:0]   t4e, tax, tay;

   always_comb begin
      gxs = f_pxw_ff[XW-1:F];
      gys = f_pyw_ff[XW-1:F];
      t4e = GW'($signed({1'b0, f_t4_ff}));
      case (f_ax_ff)
         2'sb01:  tax = t4e;
         2'sb11:  tax = -t4e;
         default: tax = '0;
      endcase
      case (f_ay_ff)
         2'sb01:  tay = t4e;
         2'sb11:  tay = -t4e;
         default: tay = '0;
      endcase
      part_in.noise  = GW'(f_n_ff);
      part_in.grad_x = tax - (GW'(gxs) <<< 3);
      part_in.grad_y = tay - (GW'(gys) <<< 3);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_sqx_ff <= pos_x * pos_x;
         a_sqy_ff <= pos_y * pos_y;
         a_v_ff   <= a_v_in;
         a_ax_ff  <= ax_w;
         a_ay_ff  <= ay_w;
         a_px_ff  <= pos_x;
         a_py_ff  <= pos_y;

         b_t_ff  <= b_t_in;
         b_v_ff  <= a_v_ff;
         b_ax_ff <= a_ax_ff;
         b_ay_ff <= a_ay_ff;
         b_px_ff <= a_px_ff;
         b_py_ff <= a_py_ff;

         c_tt_ff <= b_t_ff * b_t_ff;
         c_t_ff  <= b_t_ff;
         c_v_ff  <= b_v_ff;
         c_ax_ff <= b_ax_ff;
         c_ay_ff <= b_ay_ff;
         c_px_ff <= b_px_ff;
         c_py_ff <= b_py_ff;

         d_t3p_ff <= t2 * c_t_ff;
         d_t4p_ff <= t2 * t2;
         d_v_ff   <= c_v_ff;
         d_ax_ff  <= c_ax_ff;
         d_ay_ff  <= c_ay_ff;
         d_px_ff  <= c_px_ff;
         d_py_ff  <= c_py_ff;

         e_t4v_ff <= $signed({1'b0, t4}) * d_v_ff;
         e_t3v_ff <= $signed({1'b0, t3}) * d_v_ff;
         e_t4_ff  <= t4;
         e_ax_ff  <= d_ax_ff;
         e_ay_ff  <= d_ay_ff;
         e_px_ff  <= d_px_ff;
         e_py_ff  <= d_py_ff;

         f_n_ff   <= e_t4v_ff[MW-1:F];
         f_pxw_ff <= e_px_ff * w;
         f_pyw_ff <= e_py_ff * w;
         f_t4_ff  <= e_t4_ff;
         f_ax_ff  <= e_ax_ff;
         f_ay_ff  <= e_ay_ff;

         part_ff <= part_in;
      end
   end

   assign part = part_ff;

endmodule

@@ hw/rtl/simplex_noise_2d_with_gradient.sv @@
// 2D simplex noise with analytic gradient. Each evaluate transfer carries a point in
// signed Q16.16 and yields one result transfer with the noise value and its x and y
// derivatives in signed Q8.16, clamped to the 24-bit range. Load transfers rewrite one
// byte of the 256-entry permutation and yield no result. The block takes one transfer
// per clock while it is not held; every item runs through a fixed 14-stage pipeline
// (skew multiply, floor, unskew multiply, two permutation lookups, then a 7-stage
// corner unit per corner and a final sum) and then the output register that drives
// rsp_tvalid. A two-deep output buffer lets input continue while a result waits; the
// whole pipeline holds only once both entries are full. After reset the block fills
// all 256 entries of the permutation copies with the default table and keeps
// req_tready low until that pass ends. The permutation lives in three copies, each
// updated by every load at the point in the pipeline where that copy is read, so
// loads and evaluations always act in transfer order.
module simplex_noise_2d_with_gradient (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // x_pos[31:0], y_pos[63:32], table_index[71:64],
                                    // table_value[79:72]
   input  logic [0:0]  req_tuser,   // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // noise_value[23:0], grad_x[47:24], grad_y[71:48]
);

   localparam int F    = snd_pkg::FRAC_BITS;
   localparam int PW   = snd_pkg::POS_W;
   localparam int CW   = snd_pkg::CI_W;
   localparam int IW   = snd_pkg::IDX_W;
   localparam int SW   = snd_pkg::SUM_W;
   localparam int LAST = 6 + snd_pkg::CORNER_LAT;

   logic adv;
   logic acc;

   // reset fill pass over the permutation copies
   logic [IW-1:0] init_cnt_ff;
   logic          init_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_cnt_ff  <= '0;
         init_done_ff <= 1'b0;
      end else if (!init_done_ff) begin
         init_cnt_ff <= init_cnt_ff + 1'b1;
         if (init_cnt_ff == IW'(snd_pkg::TABLE_ENTRIES - 1)) begin
            init_done_ff <= 1'b1;
         end
      end
   end

   // valid and opcode travel with each stage
   logic [LAST:0] vld_ff;
   logic [LAST:0] op_ff;

   assign req_tready = adv && init_done_ff;
   assign acc        = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], acc};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff <= {op_ff[LAST-1:0], req_tuser[0]};
      end
   end

   // stage 0: capture
   logic signed [31:0] s0_x_ff, s0_y_ff;
   logic [IW-1:0]      s0_idx_ff, s0_val_ff;

   // stage 1: skew product (x + y) * F2
   logic signed [32:0] s1_sum;
   logic signed [65:0] s1_prod_ff;
   logic signed [31:0] s1_x_ff, s1_y_ff;
   logic [IW-1:0]      s1_idx_ff, s1_val_ff;

   assign s1_sum = 33'(s0_x_ff) + 33'(s0_y_ff);

   // stage 2: floor to lattice cell
   logic signed [33:0] s2_s;
   logic signed [34:0] s2_xs, s2_ys;
   logic signed [CW-1:0] s2_ci_ff, s2_cj_ff;
   logic signed [31:0] s2_x_ff, s2_y_ff;
   logic [IW-1:0]      s2_idx_ff, s2_val_ff;

   always_comb begin
      s2_s  = s1_prod_ff[65:32];
      s2_xs = 35'(s1_x_ff) + 35'(s2_s);
      s2_ys = 35'(s1_y_ff) + 35'(s2_s);
   end

   // stage 3: unskew product, first permutation lookup
   logic signed [CW:0]    s3_csum;
   logic signed [CW+31:0] s3_prod_ff;
   logic signed [CW-1:0]  s3_ci_ff, s3_cj_ff;
   logic signed [31:0]    s3_x_ff, s3_y_ff;
   logic [IW-1:0]         s3_idx_ff, s3_val_ff;
   logic [IW-1:0]         s3_pa_ff, s3_pb_ff;

   assign s3_csum = (CW + 1)'(s2_ci_ff) + (CW + 1)'(s2_cj_ff);

   // stage 4: cell offsets and corner order
   logic signed [CW+F-1:0] s4_t;
   logic signed [35:0]     s4_x0_full, s4_y0_full;
   logic signed [PW-1:0]   s4_x0_in, s4_y0_in;
   logic signed [PW-1:0]   s4_x0_ff, s4_y0_ff;
   logic                   s4_i1_ff;
   logic [IW-1:0]          s4_ii_ff, s4_pa_ff, s4_pb_ff;
   logic [IW-1:0]          s4_idx_ff, s4_val_ff;

   always_comb begin
      s4_t       = s3_prod_ff[CW+31:32-F];
      s4_x0_full = 36'(s3_x_ff) - 36'($signed({s3_ci_ff, {F{1'b0}}})) + 36'(s4_t);
      s4_y0_full = 36'(s3_y_ff) - 36'($signed({s3_cj_ff, {F{1'b0}}})) + 36'(s4_t);
      s4_x0_in   = s4_x0_full[PW-1:0];
      s4_y0_in   = s4_y0_full[PW-1:0];
   end

   // stage 5: corner positions and gradient hashes
   logic [IW-1:0]        a0, a1, a2;
   logic signed [PW-1:0] s5_p0x_ff, s5_p0y_ff, s5_p1x_ff, s5_p1y_ff, s5_p2x_ff, s5_p2y_ff;
   logic [2:0]           s5_h0_ff, s5_h1_ff, s5_h2_ff;

   always_comb begin
      a0 = s4_ii_ff + s4_pa_ff;
      a1 = s4_ii_ff + IW'(s4_i1_ff) + (s4_i1_ff ? s4_pa_ff : s4_pb_ff);
      a2 = s4_ii_ff + IW'(1) + s4_pb_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_x_ff   <= req_tdata[31:0];
         s0_y_ff   <= req_tdata[63:32];
         s0_idx_ff <= req_tdata[71:64];
         s0_val_ff <= req_tdata[79:72];

         s1_prod_ff <= s1_sum * snd_pkg::F2_Q32;
         s1_x_ff    <= s0_x_ff;
         s1_y_ff    <= s0_y_ff;
         s1_idx_ff  <= s0_idx_ff;
         s1_val_ff  <= s0_val_ff;

         s2_ci_ff  <= s2_xs[34:F];
         s2_cj_ff  <= s2_ys[34:F];
         s2_x_ff   <= s1_x_ff;
         s2_y_ff   <= s1_y_ff;
         s2_idx_ff <= s1_idx_ff;
         s2_val_ff <= s1_val_ff;

         s3_prod_ff <= s3_csum * snd_pkg::G2_Q32;
         s3_ci_ff   <= s2_ci_ff;
         s3_cj_ff   <= s2_cj_ff;
         s3_x_ff    <= s2_x_ff;
         s3_y_ff    <= s2_y_ff;
         s3_idx_ff  <= s2_idx_ff;
         s3_val_ff  <= s2_val_ff;

         s4_x0_ff  <= s4_x0_in;
         s4_y0_ff  <= s4_y0_in;
         s4_i1_ff  <= (s4_x0_in > s4_y0_in);
         s4_ii_ff  <= s3_ci_ff[IW-1:0];
         s4_pa_ff  <= s3_pa_ff;
         s4_pb_ff  <= s3_pb_ff;
         s4_idx_ff <= s3_idx_ff;
         s4_val_ff <= s3_val_ff;

         s5_p0x_ff <= s4_x0_ff;
         s5_p0y_ff <= s4_y0_ff;
         s5_p1x_ff <= s4_x0_ff - (s4_i1_ff ? snd_pkg::ONE_POS : '0) + snd_pkg::G2F_POS;
         s5_p1y_ff <= s4_y0_ff - (s4_i1_ff ? '0 : snd_pkg::ONE_POS) + snd_pkg::G2F_POS;
         s5_p2x_ff <= s4_x0_ff + snd_pkg::G2F2_POS;
         s5_p2y_ff <= s4_y0_ff + snd_pkg::G2F2_POS;
      end
   end

   // permutation copies: one for the row lookup, two for the hash lookup
   logic [7:0] perm_row_mem [snd_pkg::TABLE_ENTRIES];
   logic [7:0] perm_hash_mem [snd_pkg::TABLE_ENTRIES];
   logic [7:0] perm_last_mem [snd_pkg::TABLE_ENTRIES];

   logic          row_we, hash_we;
   logic [IW-1:0] row_wa, hash_wa;
   logic [7:0]    row_wd, hash_wd;

   always_comb begin
      row_we  = !init_done_ff ||
                (adv && vld_ff[2] && (op_ff[2] == snd_pkg::OP_LOAD));
      hash_we = !init_done_ff ||
                (adv && vld_ff[4] && (op_ff[4] == snd_pkg::OP_LOAD));
      row_wa  = init_done_ff ? s2_idx_ff : init_cnt_ff;
      hash_wa = init_done_ff ? s4_idx_ff : init_cnt_ff;
      row_wd  = init_done_ff ? s2_val_ff : snd_pkg::DEFAULT_PERM[init_cnt_ff];
      hash_wd = init_done_ff ? s4_val_ff : snd_pkg::DEFAULT_PERM[init_cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         perm_row_mem[row_wa] <= row_wd;
      end
      if (adv) begin
         s3_pa_ff <= perm_row_mem[s2_cj_ff[IW-1:0]];
         s3_pb_ff <= perm_row_mem[s2_cj_ff[IW-1:0] + IW'(1)];
      end
   end

   always_ff @(posedge clock) begin
      if (hash_we) begin
         perm_hash_mem[hash_wa] <= hash_wd;
      end
      if (adv) begin
         s5_h0_ff <= perm_hash_mem[a0][2:0];
         s5_h1_ff <= perm_hash_mem[a1][2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (hash_we) begin
         perm_last_mem[hash_wa] <= hash_wd;
      end
      if (adv) begin
         s5_h2_ff <= perm_last_mem[a2][2:0];
      end
   end

   // three corner units
   snd_pkg::corner_out_type c0_part, c1_part, c2_part;

   snd_corner u_corner0 (
      .clock (clock),
      .adv   (adv),
      .pos_x (s5_p0x_ff),
      .pos_y (s5_p0y_ff),
      .hash  (s5_h0_ff),
      .part  (c0_part)
   );

   snd_corner u_corner1 (
      .clock (clock),
      .adv   (adv),
      .pos_x (s5_p1x_ff),
      .pos_y (s5_p1y_ff),
      .hash  (s5_h1_ff),
      .part  (c1_part)
   );

   snd_corner u_corner2 (
      .clock (clock),
      .adv   (adv),
      .pos_x (s5_p2x_ff),
      .pos_y (s5_p2y_ff),
      .hash  (s5_h2_ff),
      .part  (c2_part)
   );

   // last stage: sum the corners
   logic signed [SW-1:0] n_sum_ff, gx_sum_ff, gy_sum_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         n_sum_ff  <= SW'(c0_part.noise) + SW'(c1_part.noise) + SW'(c2_part.noise);
         gx_sum_ff <= SW'(c0_part.grad_x) + SW'(c1_part.grad_x) + SW'(c2_part.grad_x);
         gy_sum_ff <= SW'(c0_part.grad_y) + SW'(c1_part.grad_y) + SW'(c2_part.grad_y);
      end
   end

   // output register plus skid entry; the pipeline holds only when the skid is full
   logic          res_vld;
   logic [71:0]   res_data;
   logic          ov_ff, kv_ff;
   logic [71:0]   o_data_ff, k_data_ff;

   assign adv      = !kv_ff;
   assign res_vld  = vld_ff[LAST] && (op_ff[LAST] == snd_pkg::OP_EVAL);
   assign res_data = {snd_pkg::scale_sat(gy_sum_ff), snd_pkg::scale_sat(gx_sum_ff),
                      snd_pkg::scale_sat(n_sum_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
         kv_ff <= 1'b0;
      end else if (adv) begin
         if (ov_ff && !rsp_tready) begin
            kv_ff <= res_vld;
         end else begin
            ov_ff <= res_vld;
         end
      end else if (rsp_tready) begin
         kv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (ov_ff && !rsp_tready) begin
            k_data_ff <= res_data;
         end else begin
            o_data_ff <= res_data;
         end
      end else if (rsp_tready) begin
         o_data_ff <= k_data_ff;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = o_data_ff;

`ifndef SYNTH
   // skid entry fills only behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      kv_ff |-> ov_ff)
      else $error("skid entry valid without output valid");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(kv_ff) |-> $past(ov_ff && !rsp_tready))
      else $error("skid filled while output was free");

   // no transfer while the permutation copies are still being filled
   a_no_accept_in_fill: assert property (@(posedge clock) disable iff (reset)
      !init_done_ff |-> !req_tready)
      else $error("input accepted during fill pass");

   a_fill_done: assert property (@(posedge clock) disable iff (reset)
      $rose(init_done_ff) |-> $past(init_cnt_ff == IW'(snd_pkg::TABLE_ENTRIES - 1)))
      else $error("fill pass ended early");
`endif

endmodule

@@ bench/simplex_noise_checker.sv @@
`timescale 1ns / 1ps

module simplex_noise_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);

   logic [7:0]  perm_copy [snd_pkg::TABLE_ENTRIES];
   logic [71:0] expected_noise_q [$];

   function automatic longint gtx(input logic [2:0] h);
      case (h)
         3'd0, 3'd2, 3'd4: return -1;
         3'd5, 3'd6:       return 0;
         default:          return 1;
      endcase
   endfunction

   function automatic longint gty(input logic [2:0] h);
      case (h)
         3'd0, 3'd5, 3'd7: return -1;
         3'd1, 3'd2:       return 0;
         default:          return 1;
      endcase
   endfunction

   function automatic void add_corner(input longint px, input longint py,
                                      input logic [7:0] h,
                                      inout longint n, inout longint gx, inout longint gy);
      longint ax, ay, v, t, t2, t3, t4, w;
      ax = gtx(h[2:0]);
      ay = gty(h[2:0]);
      v  = ax * px + ay * py;
      t  = (64'sd1 <<< (2 * snd_pkg::FRAC_BITS - 1)) - (px * px + py * py);
      if (t < 0) t = 0;
      t  = t >>> snd_pkg::FRAC_BITS;
      t2 = (t * t) >>> snd_pkg::FRAC_BITS;
      t3 = (t2 * t) >>> snd_pkg::FRAC_BITS;
      t4 = (t2 * t2) >>> snd_pkg::FRAC_BITS;
      n  = n + ((t4 * v) >>> snd_pkg::FRAC_BITS);
      w  = (t3 * v) >>> snd_pkg::FRAC_BITS;
      gx = gx - 8 * ((px * w) >>> snd_pkg::FRAC_BITS) + ax * t4;
      gy = gy - 8 * ((py * w) >>> snd_pkg::FRAC_BITS) + ay * t4;
   endfunction

   function automatic logic [23:0] clamp24(input longint v);
      if (v > 64'sd8388607) return 24'h7FFFFF;
      if (v < -64'sd8388608) return 24'h800000;
      return v[23:0];
   endfunction

   // noise, grad_x and grad_y packed as on rsp_tdata
   function automatic logic [71:0] noise_at(input logic signed [31:0] xp,
                                            input logic signed [31:0] yp);
      longint one, x, y, s, ci, cj, t, x0, y0, g2f, n, gx, gy;
      logic [7:0] ii, jj, h0, h1, h2;
      logic i1, j1;
      one = 64'sd1 <<< snd_pkg::FRAC_BITS;
      x   = xp;
      y   = yp;
      s   = ((x + y) * 64'sd1572067139) >>> 32;
      ci  = (x + s) >>> snd_pkg::FRAC_BITS;
      cj  = (y + s) >>> snd_pkg::FRAC_BITS;
      t   = ((ci + cj) * 64'sd907633386) >>> (32 - snd_pkg::FRAC_BITS);
      x0  = x - ci * one + t;
      y0  = y - cj * one + t;
      g2f = (64'sd907633386 + (64'sd1 <<< (31 - snd_pkg::FRAC_BITS)))
            >>> (32 - snd_pkg::FRAC_BITS);
      i1  = x0 > y0;
      j1  = !i1;
      ii  = ci[7:0];
      jj  = cj[7:0];
      // index sums wrap in 8 bits
      h0  = perm_copy[8'(ii + perm_copy[jj])];
      h1  = perm_copy[8'(ii + i1 + perm_copy[8'(jj + j1)])];
      h2  = perm_copy[8'(ii + 8'd1 + perm_copy[8'(jj + 8'd1)])];
      n = 0; gx = 0; gy = 0;
      add_corner(x0, y0, h0, n, gx, gy);
      add_corner(x0 - (i1 ? one : 0) + g2f, y0 - (j1 ? one : 0) + g2f, h1, n, gx, gy);
      add_corner(x0 - one + 2 * g2f, y0 - one + 2 * g2f, h2, n, gx, gy);
      return {clamp24(40 * gy), clamp24(40 * gx), clamp24(40 * n)};
   endfunction

   assign pending_count = expected_noise_q.size();

   always @(posedge clock) begin
      logic [71:0] exp_v;
      if (reset) begin
         foreach (perm_copy[k]) perm_copy[k] = snd_pkg::DEFAULT_PERM[k];
         expected_noise_q.delete();
         fail_count   <= 0;
         result_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (snd_pkg::opcode_type'(req_tuser[0]) == snd_pkg::OP_LOAD)
               perm_copy[req_tdata[71:64]] = req_tdata[79:72];
            else
               expected_noise_q.push_back(noise_at(req_tdata[31:0], req_tdata[63:32]));
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            if (expected_noise_q.size() == 0) begin
               $error("unexpected result transfer %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               exp_v = expected_noise_q.pop_front();
               if (rsp_tdata[23:0] !== exp_v[23:0])
                  $error("noise_value expected %h actual %h", exp_v[23:0], rsp_tdata[23:0]);
               if (rsp_tdata[47:24] !== exp_v[47:24])
                  $error("grad_x expected %h actual %h", exp_v[47:24], rsp_tdata[47:24]);
               if (rsp_tdata[71:48] !== exp_v[71:48])
                  $error("grad_y expected %h actual %h", exp_v[71:48], rsp_tdata[71:48]);
               if (rsp_tdata !== exp_v) fail_count <= fail_count + 1;
            end
         end
      end
   end

endmodule

@@ bench/tb_simplex_noise_2d_with_gradient.sv @@
`timescale 1ns / 1ps

module tb_simplex_noise_2d_with_gradient;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;

   int fail_count, pending_count, result_count;
   int eval_sent = 0, load_sent = 0;
   bit no_idle = 1'b0;        // set during stretches with back-to-back traffic
   int rsp_stall = 0;
   bit rsp_moved = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   simplex_noise_2d_with_gradient u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   simplex_noise_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   // note each result transfer so the stall for the next one is drawn fresh
   always @(posedge clock) rsp_moved <= rsp_tvalid && rsp_tready && !reset;

   // receiver: hold off a random number of cycles before each result
   always @(negedge clock) begin
      if (rsp_moved) rsp_stall = no_idle ? 0 : $urandom_range(0, 11);
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // present one item after a random gap and hold it until its transfer
   task automatic send_item(input snd_pkg::opcode_type op, input logic [31:0] xp,
                            input logic [31:0] yp, input logic [7:0] idx,
                            input logic [7:0] val);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {val, idx, yp, xp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (op == snd_pkg::OP_EVAL) eval_sent++;
      else load_sent++;
   endtask

   task automatic eval_point(input logic [31:0] xp, input logic [31:0] yp);
      send_item(snd_pkg::OP_EVAL, xp, yp, 8'($urandom), 8'($urandom));
   endtask

   task automatic load_entry(input logic [7:0] idx, input logic [7:0] val);
      send_item(snd_pkg::OP_LOAD, $urandom, $urandom, idx, val);
   endtask

   // coordinate drawn mostly near the origin, sometimes across the full range
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return 32'($signed($urandom_range(0, 2 * 65536 * 300)) - 65536 * 300);
         default: return 32'($signed($urandom_range(0, 2 * 65536 * 4)) - 65536 * 4);
      endcase
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: origin, lattice points, corner order on both sides, extremes
      eval_point(32'h0, 32'h0);
      eval_point(32'h0001_0000, 32'h0);
      eval_point(32'h0000_8000, 32'h0000_2000);   // x0 > y0
      eval_point(32'h0000_2000, 32'h0000_8000);   // x0 <= y0
      eval_point(32'h0000_4000, 32'h0000_4000);
      eval_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      eval_point(32'h8000_0000, 32'h8000_0000);
      eval_point(32'h7FFF_FFFF, 32'h8000_0000);
      eval_point(32'h8000_0000, 32'h7FFF_FFFF);
      eval_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      eval_point(32'h00FF_8000, 32'h00FF_C000);   // index sums wrap past 255
      eval_point(32'hFF00_4000, 32'h0100_2000);
      // rewrite both ends of the store, then evaluate near the points (0,0) and (255,255)
      load_entry(8'd0, 8'd255);
      load_entry(8'd255, 8'd0);
      eval_point(32'h0000_3000, 32'h0000_1000);
      eval_point(32'h00FF_3000, 32'h00FF_1000);
      // sweep every gradient at the origin corner
      for (int g = 0; g < 8; g++) begin
         load_entry(8'd0, 8'(g));
         load_entry(8'(g), 8'(g));
         eval_point(32'h0000_1800, 32'h0000_0800);
      end

      // random: mostly evaluations, loads mixed in, with stretches of no idling
      for (int k = 0; k < 930; k++) begin
         if (k % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 9) == 0) load_entry(8'($urandom), 8'($urandom));
         else eval_point(pick_coord(), pick_coord());
      end
      req_tvalid <= 1'b0;
      no_idle = 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("run covered %0d evaluations and %0d permutation loads, %0d results checked",
               eval_sent, load_sent, result_count);
      if (fail_count == 0) begin
         $display("simplex_noise_2d_with_gradient: match");
      end else begin
         $display("simplex_noise_2d_with_gradient: mismatch");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #8_000_000;
      $display("simplex_noise_2d_with_gradient: mismatch");
      $finish;
   end

endmodule

@@ simplex_noise_2d_with_gradient.f @@
hw/rtl/snd_pkg.sv
hw/rtl/snd_corner.sv
hw/rtl/simplex_noise_2d_with_gradient.sv
bench/simplex_noise_checker.sv
bench/tb_simplex_noise_2d_with_gradient.sv
